// ===== rtl/sgfa_pkg.sv =====
// Shared types and constants for the softened gravity force accumulator.
// Used by sgfa_front, sgfa_back and the top level.
package sgfa_pkg;

  localparam int PosW  = 24;
  localparam int MassW = 24;
  localparam int SumW  = 48;
  localparam int FW    = 47;
  localparam int CfgW  = 32;

  localparam logic CFG_GRAVITY   = 1'b0;
  localparam logic CFG_SOFTENING = 1'b1;

  localparam logic [CfgW-1:0] GRAVITY_RESET   = 32'd65536;
  localparam logic [CfgW-1:0] SOFTENING_RESET = 32'd983040;

  typedef struct packed {
    logic [PosW-1:0]  self_x;
    logic [PosW-1:0]  self_y;
    logic [MassW-1:0] self_mass;
    logic [PosW-1:0]  other_x;
    logic [PosW-1:0]  other_y;
    logic [MassW-1:0] other_mass;
    logic             other_valid;
    logic             first;
    logic             last;
  } item_t;

  typedef struct packed {
    logic signed [SumW-1:0] force_x;
    logic signed [SumW-1:0] force_y;
    logic                   saturated;
  } result_t;

  // Classified neighbor command passed from front to back.
  typedef struct packed {
    logic signed [PosW:0] dx;
    logic signed [PosW:0] dy;
    logic [MassW-1:0]     m1;
    logic [MassW-1:0]     m2;
    logic                 active;
    logic                 first;
    logic                 last;
  } cmd_t;

endpackage

// ===== rtl/sgfa_front.sv =====
// Front end: accepts items, forms the position deltas, classifies the item
// and holds it in a short command queue. Depends on sgfa_pkg.
module sgfa_front import sgfa_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  head_valid,
  output cmd_t  head,
  input  logic  pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          queue [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  cmd_t          cmd_in;

  assign item_stall = (count == CW'(QDEPTH));
  assign push       = item_valid && !item_stall;
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  always_comb begin
    cmd_in.dx     = $signed({1'b0, item.other_x}) - $signed({1'b0, item.self_x});
    cmd_in.dy     = $signed({1'b0, item.other_y}) - $signed({1'b0, item.self_y});
    cmd_in.m1     = item.self_mass;
    cmd_in.m2     = item.other_mass;
    // zero distance contributes nothing, same as an empty item
    cmd_in.active = item.other_valid &&
                    ((item.other_x != item.self_x) || (item.other_y != item.self_y));
    cmd_in.first  = item.first;
    cmd_in.last   = item.last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty command queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QDEPTH))
    else $error("command queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(QDEPTH)) |-> !push)
    else $error("transfer accepted into a full command queue");

endmodule

// ===== rtl/sgfa_back.sv =====
// Back end: sequencer that computes squared distance, integer root, softened
// force and the two axis terms with one shared restoring divider, then
// accumulates and emits. Holds the configuration registers. Depends on sgfa_pkg.
module sgfa_back import sgfa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cmd_t            head,
  output logic            pop,
  input  logic            cfg_valid,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output logic            result_valid,
  input  logic            result_stall,
  output result_t         result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQ2  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_GM   = 4'd4;
  localparam logic [3:0] S_NLO  = 4'd5;
  localparam logic [3:0] S_NHI  = 4'd6;
  localparam logic [3:0] S_NSUM = 4'd7;
  localparam logic [3:0] S_FCHK = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_AML  = 4'd10;
  localparam logic [3:0] S_AMH  = 4'd11;
  localparam logic [3:0] S_ALD  = 4'd12;
  localparam logic [3:0] S_ACC  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  localparam logic [FW-1:0] F_CAP = {FW{1'b1}};
  localparam logic signed [SumW:0] SUM_MAX = {2'b00, {(SumW-1){1'b1}}};
  localparam logic signed [SumW:0] SUM_MIN = {2'b11, {(SumW-1){1'b0}}};

  logic [3:0]  state;
  logic [CfgW-1:0] gravity;
  logic [CfgW-1:0] softening;
  cmd_t        cmd;
  logic [47:0] sq_a;
  logic [48:0] d2;
  logic [49:0] d2sh;
  logic [24:0] root;
  logic [26:0] srem;
  logic [4:0]  scnt;
  logic [55:0] gm;
  logic [55:0] plo;
  logic [47:0] phi;
  logic [95:0] num;
  logic [49:0] denom;
  logic [49:0] drem;
  logic [FW-1:0] dnum;
  logic [FW-1:0] dq;
  logic [49:0] ddiv;
  logic [5:0]  dcnt;
  logic        div_axis;
  logic [FW-1:0] f;
  logic        axis;
  logic [47:0] pa;
  logic [46:0] pb;
  logic signed [SumW-1:0] sum_x;
  logic signed [SumW-1:0] sum_y;
  logic        sat;

  logic [PosW-1:0] mx, my, mag;
  logic signed [PosW:0] cur_d;
  logic        neg;
  logic [48:0] d2_c;
  logic [28:0] sh, trial;
  logic [50:0] dt, ddiff;
  logic        dge;
  logic [FW-1:0] dq_next;
  logic [70:0] prod;
  logic signed [SumW:0] term, acc_in, acc_sum;
  logic signed [SumW-1:0] acc_clamped;
  logic        acc_ovf;
  logic        out_free;

  assign pop      = (state == S_IDLE) && head_valid;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    mx    = cmd.dx[PosW] ? PosW'(-cmd.dx) : cmd.dx[PosW-1:0];
    my    = cmd.dy[PosW] ? PosW'(-cmd.dy) : cmd.dy[PosW-1:0];
    cur_d = axis ? cmd.dy : cmd.dx;
    neg   = cur_d[PosW];
    mag   = axis ? my : mx;
    d2_c  = {1'b0, sq_a} + {1'b0, 48'(my * my)};
    sh    = {srem, d2sh[49:48]};
    trial = {2'b00, root, 2'b01};
    dt    = {drem, dnum[FW-1]};
    dge   = dt >= {1'b0, ddiv};
    ddiff = dt - {1'b0, ddiv};
    dq_next = {dq[FW-2:0], dge};
    prod  = {pb, 24'b0} + {23'b0, pa};
    term  = neg ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
    acc_in  = axis ? {sum_y[SumW-1], sum_y} : {sum_x[SumW-1], sum_x};
    acc_sum = acc_in + term;
    acc_ovf = acc_sum[SumW] != acc_sum[SumW-1];
    if (!acc_ovf) begin
      acc_clamped = acc_sum[SumW-1:0];
    end else if (acc_sum[SumW]) begin
      acc_clamped = SUM_MIN[SumW-1:0];
    end else begin
      acc_clamped = SUM_MAX[SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity   <= GRAVITY_RESET;
      softening <= SOFTENING_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRAVITY:   gravity   <= cfg_data;
        CFG_SOFTENING: softening <= cfg_data;
        default:       ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    unique case (state)
      S_SQ: begin
        sq_a <= 48'(mx * mx);
      end
      S_SQ2: begin
        d2   <= d2_c;
        d2sh <= {1'b0, d2_c};
        root <= '0;
        srem <= '0;
      end
      S_SQRT: begin
        d2sh <= {d2sh[47:0], 2'b00};
        if (sh >= trial) begin
          srem <= 27'(sh - trial);
          root <= {root[23:0], 1'b1};
        end else begin
          srem <= sh[26:0];
          root <= {root[23:0], 1'b0};
        end
      end
      S_GM: begin
        gm <= 56'(gravity * cmd.m1);
      end
      S_NLO: begin
        plo <= 56'(gm[31:0] * cmd.m2);
      end
      S_NHI: begin
        phi <= 48'(gm[55:32] * cmd.m2);
      end
      S_NSUM: begin
        num   <= {({phi, 32'b0} + {24'b0, plo}), 16'b0};
        denom <= {1'b0, d2} + {18'b0, softening};
      end
      S_FCHK: begin
        if ({1'b0, num} >= {denom, 47'b0}) begin
          f <= F_CAP;
        end else begin
          drem     <= {1'b0, num[95:47]};
          dnum     <= num[46:0];
          ddiv     <= denom;
          dq       <= '0;
          div_axis <= 1'b0;
        end
      end
      S_DIV: begin
        drem <= dge ? ddiff[49:0] : dt[49:0];
        dnum <= {dnum[FW-2:0], 1'b0};
        dq   <= dq_next;
        if (!div_axis) begin
          f <= dq_next;
        end
      end
      S_AML: begin
        pa <= 48'(f[23:0] * mag);
      end
      S_AMH: begin
        pb <= 47'(f[46:24] * mag);
      end
      S_ALD: begin
        drem     <= {26'b0, prod[70:47]};
        dnum     <= prod[46:0];
        ddiv     <= {25'b0, root};
        dq       <= '0;
        div_axis <= 1'b1;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scnt         <= '0;
      dcnt         <= '0;
      axis         <= 1'b0;
      sum_x        <= '0;
      sum_y        <= '0;
      sat          <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.first) begin
              sum_x <= '0;
              sum_y <= '0;
              sat   <= 1'b0;
            end
            state <= head.active ? S_SQ : S_OUT;
          end
        end
        S_SQ:  state <= S_SQ2;
        S_SQ2: begin
          scnt  <= 5'd24;
          state <= S_SQRT;
        end
        S_SQRT: begin
          scnt <= scnt - 1'b1;
          if (scnt == '0) begin
            state <= S_GM;
          end
        end
        S_GM:   state <= S_NLO;
        S_NLO:  state <= S_NHI;
        S_NHI:  state <= S_NSUM;
        S_NSUM: state <= S_FCHK;
        S_FCHK: begin
          axis <= 1'b0;
          if ({1'b0, num} >= {denom, 47'b0}) begin
            sat   <= 1'b1;
            state <= S_AML;
          end else begin
            dcnt  <= 6'(FW - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            state <= div_axis ? S_ACC : S_AML;
          end
        end
        S_AML: state <= S_AMH;
        S_AMH: state <= S_ALD;
        S_ALD: begin
          dcnt  <= 6'(FW - 1);
          state <= S_DIV;
        end
        S_ACC: begin
          if (axis) begin
            sum_y <= acc_clamped;
          end else begin
            sum_x <= acc_clamped;
          end
          if (acc_ovf) begin
            sat <= 1'b1;
          end
          if (axis) begin
            state <= S_OUT;
          end else begin
            axis  <= 1'b1;
            state <= S_AML;
          end
        end
        S_OUT: begin
          if (!cmd.last || out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && cmd.last && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && cmd.last && out_free) begin
      result.force_x   <= sum_x;
      result.force_y   <= sum_y;
      result.saturated <= sat;
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (drem < ddiv))
    else $error("divider remainder not below divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> ({2'b00, srem} <= {3'b000, root, 1'b0}))
    else $error("root remainder out of range");

  a_sat_clear: assert property (@(posedge clk) disable iff (rst)
    ($fell(sat) && $past(!rst)) |-> $past(pop && head.first))
    else $error("saturation flag dropped without a first item");

endmodule

// ===== rtl/softened_gravity_force_accumulator_top.sv =====
// Accumulates the softened 2D gravitational force of a run of neighbors on one
// body; an item marked last yields one result, an item marked first clears
// the sums. A neighbor item occupies the back end for a 25-step integer root
// and up to three 47-step divisions in one shared bit-serial divider (the
// force division is skipped when capped); empty or zero-distance items skip both.
// A small command queue lets items be accepted while the back end works.
module softened_gravity_force_accumulator_top import sgfa_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  item_t           item,
  output logic            result_valid,
  input  logic            result_stall,
  output result_t         result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  logic head_valid;
  cmd_t head;
  logic pop;

  assign cfg_ready = 1'b1;

  sgfa_front #(
    .QDEPTH(QDEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  sgfa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== verif/tb_softened_gravity_force_accumulator_top.sv =====
// Self-checking bench for softened_gravity_force_accumulator_top: runs directed and random
// neighbor runs through a local force predictor and checks every emitted force vector.
// Depends on sgfa_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_softened_gravity_force_accumulator_top;
  import sgfa_pkg::*;

  localparam logic [127:0] F_LIMIT = 128'h7FFF_FFFF_FFFF;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh0000_8000_0000_0000;
  localparam int POS_MAX = (1 << PosW) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_GRAVITY;
  logic [CfgW-1:0] cfg_data = '0;

  softened_gravity_force_accumulator_top DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t pending_items[$];
  result_t force_expected[$];
  logic [CfgW-1:0] grav_g = GRAVITY_RESET;
  logic [CfgW-1:0] soft_eps = SOFTENING_RESET;
  longint acc_x = 0;
  longint acc_y = 0;
  bit acc_sat = 1'b0;
  int fail_count = 0;
  int idle_pct = 0;
  int results_seen = 0;

  function automatic void enqueue_item(item_t it);
    pending_items = {pending_items, it};
  endfunction

  task automatic report(string what, logic [SumW-1:0] got, logic [SumW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_add(longint a, longint t);
    longint s;
    s = a + t;
    if (s > SUM_HI) begin
      acc_sat = 1'b1;
      return SUM_HI;
    end
    if (s < SUM_LO) begin
      acc_sat = 1'b1;
      return SUM_LO;
    end
    return s;
  endfunction

  function automatic longint axis_pull(logic [127:0] f, longint d, logic [63:0] root_len);
    logic [127:0] q;
    q = (f * 128'(d < 0 ? -d : d)) / 128'(root_len);
    if (q > F_LIMIT) begin
      acc_sat = 1'b1;
      q = F_LIMIT;
    end
    return d < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Update the running sums for one accepted item; queue a force vector on last.
  function automatic void accumulate_force(item_t it);
    longint dx, dy;
    logic [63:0] d2, root_len;
    logic [127:0] f;
    result_t r;
    if (it.first) begin
      acc_x = 0;
      acc_y = 0;
      acc_sat = 1'b0;
    end
    if (it.other_valid) begin
      dx = longint'(it.other_x) - longint'(it.self_x);
      dy = longint'(it.other_y) - longint'(it.self_y);
      d2 = 64'(dx * dx) + 64'(dy * dy);
      if (d2 != 0) begin
        root_len = floor_root(d2);
        f = ((128'(grav_g) * 128'(it.self_mass) * 128'(it.other_mass)) << 16)
            / (128'(d2) + 128'(soft_eps));
        if (f > F_LIMIT) begin
          acc_sat = 1'b1;
          f = F_LIMIT;
        end
        acc_x = clamp_add(acc_x, axis_pull(f, dx, root_len));
        acc_y = clamp_add(acc_y, axis_pull(f, dy, root_len));
      end
    end
    if (it.last) begin
      r.force_x = acc_x[SumW-1:0];
      r.force_y = acc_y[SumW-1:0];
      r.saturated = acc_sat;
      force_expected = {force_expected, r};
    end
  endfunction

  // Sender: advance only when the current transfer completes or nothing is offered.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) accumulate_force(item);
      if (!item_valid || !item_stall) begin
        if (send_gap != 0) begin
          item_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          item_valid <= 1'b0;
          send_gap <= $urandom_range(9, 0);
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold-off after four results.
  int rx_gap = 0;
  int hold_left = 0;
  bit held = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && results_seen >= 4) begin
      held <= 1'b1;
      hold_left <= 3000;
      result_stall <= 1'b1;
    end else if (rx_gap != 0) begin
      result_stall <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      result_stall <= 1'b1;
      rx_gap <= $urandom_range(9, 0);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (force_expected.size() == 0) begin
        report("unexpected result", result.force_x, '0);
      end else begin
        result_t want;
        want = force_expected.pop_front();
        if (result.force_x !== want.force_x) report("force_x", result.force_x, want.force_x);
        if (result.force_y !== want.force_y) report("force_y", result.force_y, want.force_y);
        if (result.saturated !== want.saturated)
          report("saturated", SumW'(result.saturated), SumW'(want.saturated));
      end
    end
  end

  task automatic write_reg(logic idx, logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRAVITY) grav_g = val;
    else soft_eps = val;
    @(posedge clk);
  endtask

  function automatic item_t mk(int sx, int sy, int m1, int ox, int oy, int m2,
                               bit v, bit f, bit l);
    item_t it;
    it.self_x = PosW'(sx); it.self_y = PosW'(sy); it.self_mass = MassW'(m1);
    it.other_x = PosW'(ox); it.other_y = PosW'(oy); it.other_mass = MassW'(m2);
    it.other_valid = v; it.first = f; it.last = l;
    return it;
  endfunction

  function automatic int near(int p, int span);
    int q;
    q = p + $urandom_range(2 * span) - span;
    return q < 0 ? 0 : (q > POS_MAX ? POS_MAX : q);
  endfunction

  // One neighbor run: mostly well-formed first..last runs, some noise.
  task automatic add_run(output int n);
    int sx, sy, m1, span;
    item_t it;
    bit noise;
    n = $urandom_range(8, 1);
    sx = $urandom_range(POS_MAX);
    sy = $urandom_range(POS_MAX);
    m1 = ($urandom_range(3) == 0) ? $urandom_range(POS_MAX) : $urandom_range(4095);
    noise = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      span = (1 << $urandom_range(23, 2));
      it = mk(sx, sy, m1, near(sx, span), near(sy, span),
              ($urandom_range(3) == 0) ? $urandom_range(POS_MAX) : $urandom_range(4095),
              $urandom_range(9) != 0, i == 0, i == n - 1);
      if ($urandom_range(19) == 0) begin
        it.other_x = it.self_x;
        it.other_y = it.self_y;
      end
      if (noise) begin
        it.first = 1'($urandom_range(1));
        it.last = 1'($urandom_range(1));
      end
      enqueue_item(it);
    end
    if (noise) enqueue_item(mk(sx, sy, m1, 0, 0, 0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || item_valid || force_expected.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  localparam logic [CfgW-1:0] GRAV_SET[5] = '{GRAVITY_RESET, 32'hFFFF_FFFF, 32'd0,
                                              32'hFFFF_FFFF, 32'd1000};
  localparam logic [CfgW-1:0] SOFT_SET[5] = '{SOFTENING_RESET, 32'hFFFF_FFFF, 32'd0,
                                              32'd0, 32'd70000};

  initial begin
    int got, n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, empty items, zero distance, force cap, sum saturation.
    enqueue_item(mk(0, 0, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1, 1, 1));
    enqueue_item(mk(POS_MAX, POS_MAX, POS_MAX, 0, 0, POS_MAX, 1, 1, 1));
    enqueue_item(mk(100, 100, 5, 100, 100, 7, 1, 1, 1));
    enqueue_item(mk(100, 100, 5, 356, 100, 7, 0, 1, 1));
    enqueue_item(mk(5000, 5000, 1, 5256, 5000, 1, 1, 1, 0));
    enqueue_item(mk(5000, 5000, 1, 5000, 4744, 1, 1, 0, 0));
    enqueue_item(mk(5000, 5000, 1, 4000, 6000, 1, 1, 0, 1));
    enqueue_item(mk(5000, 5000, 3, 5100, 5000, 9, 1, 0, 1));
    for (int i = 0; i < 4; i++)
      enqueue_item(mk(1000, 1000, POS_MAX, 1001, 1001, POS_MAX, 1, i == 0, i == 3));
    for (int i = 0; i < 4; i++)
      enqueue_item(mk(1000, 1000, POS_MAX, 999, 999, POS_MAX, 1, i == 0, i == 3));
    enqueue_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));
    idle_pct = 15;
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_GRAVITY, p == 4 ? $urandom() : GRAV_SET[p]);
      write_reg(CFG_SOFTENING, p == 4 ? $urandom() : SOFT_SET[p]);
      if (p == 2) begin
        enqueue_item(mk(300, 300, 9, 300, 300, 9, 1, 1, 1));
        enqueue_item(mk(300, 300, 9, 301, 300, 9, 1, 1, 1));
      end
      idle_pct = (p == 4) ? 0 : ((p == 1) ? 0 : 20);
      got = 0;
      while (got < 155) begin
        add_run(n);
        got += n;
      end
      enqueue_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
